FILE: rtl/mbd_pkg.sv
// mbd_pkg: shared types, constants and channel helpers for the 2x2 mipmap downsampler
// no dependencies; used by mbd_front, mbd_back and the top level
`default_nettype none

package mbd_pkg;

    localparam int MAX_WIDTH_DEF = 4096;
    localparam int CMD_DEPTH     = 4;
    localparam int OUT_DEPTH     = 4;
    localparam int CFG_BITS      = 13;

    localparam logic [CFG_BITS-1:0] HEIGHT_LIMIT = 13'd4096;
    localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 13'd2;
    localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 13'd1;

    localparam logic FMT_RGB565 = 1'b0;
    localparam logic FMT_RGB888 = 1'b1;

    localparam logic [15:0] MASK_RED   = 16'hF800;
    localparam logic [15:0] MASK_GREEN = 16'h07E0;
    localparam logic [15:0] MASK_BLUE  = 16'h001F;

    typedef enum logic [1:0] {
        CMD_STORE,
        CMD_EMIT_PAIR,
        CMD_EMIT_BLOCK
    } t_cmd_kind;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [8:0] red;
        logic [8:0] green;
        logic [8:0] blue;
    } t_sums;

    typedef struct packed {
        t_cmd_kind kind;
        logic      fmt;
        logic      row_end;
        logic      image_end;
        t_sums     sums;
    } t_cmd;

    typedef struct packed {
        logic [23:0] pixel;
        logic        row_end;
        logic        image_end;
    } t_result;

    // unpack a pixel into three channels, zero extended to a byte
    function automatic t_rgb split_pixel(input logic [23:0] pix, input logic fmt);
        t_rgb        ch;
        logic [15:0] lo;
        lo = pix[15:0];
        if (fmt == FMT_RGB565) begin
            ch.blue  = {3'b000, 5'((lo & MASK_BLUE))};
            ch.green = {2'b00, 6'((lo & MASK_GREEN) >> 5)};
            ch.red   = {3'b000, 5'((lo & MASK_RED) >> 11)};
        end else begin
            ch.blue  = pix[7:0];
            ch.green = pix[15:8];
            ch.red   = pix[23:16];
        end
        return ch;
    endfunction

    // pack channels back, keeping only the bits of each field
    function automatic logic [23:0] join_pixel(input t_rgb ch, input logic fmt);
        logic [23:0] pix;
        if (fmt == FMT_RGB565) begin
            pix = {8'h00, ch.red[4:0], ch.green[5:0], ch.blue[4:0]};
        end else begin
            pix = {ch.red, ch.green, ch.blue};
        end
        return pix;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/mbd_queue.sv
// mbd_queue: small first-in first-out buffer with occupancy count
// depends on nothing but its parameters
`default_nettype none

module mbd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [WIDTH-1:0]           i_data,
    input  wire logic                       i_pop,
    output logic      [WIDTH-1:0]           o_data,
    output logic                            o_full,
    output logic                            o_empty,
    output logic      [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_store [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_do_push, w_do_pop;

    assign w_do_push = i_push && (r_count != CW'(DEPTH));
    assign w_do_pop  = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_store[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_store[r_rd_ptr];
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

`default_nettype wire

FILE: rtl/mbd_front.sv
// mbd_front: raster position tracking, pair summing and command classification
// depends on mbd_pkg
`default_nettype none

module mbd_front #(
    parameter int MAX_WIDTH = mbd_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_accept,
    input  wire logic [23:0]                           i_pixel,
    input  wire logic                                  i_format,
    input  wire logic [mbd_pkg::CFG_BITS-1:0]          i_width,
    input  wire logic [mbd_pkg::CFG_BITS-1:0]          i_height,
    output logic                                       o_cmd_valid,
    output mbd_pkg::t_cmd                              o_cmd,
    output logic      [$clog2(MAX_WIDTH/2)-1:0]        o_cmd_addr
);

    localparam int HB = mbd_pkg::CFG_BITS;
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int AW = $clog2(MAX_WIDTH / 2);
    localparam int WW = ($clog2(MAX_WIDTH + 1) > HB) ? $clog2(MAX_WIDTH + 1) : HB;
    localparam int RW = HB - 1;

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [23:0]   r_held;

    logic [WW-1:0] w_width, w_wext, w_dw, w_dcol;
    logic [HB-1:0] w_height, w_dh, w_rhalf;
    logic          w_col_last, w_row_last, w_in_cols, w_in_rows, w_last_dcol;
    mbd_pkg::t_rgb w_a, w_b;
    mbd_pkg::t_cmd w_cmd;
    logic          w_has_cmd;

    always_comb begin
        w_wext = WW'(i_width);
        if (i_width == '0) begin
            w_width = WW'(1);
        end else if (w_wext > WW'(MAX_WIDTH)) begin
            w_width = WW'(MAX_WIDTH);
        end else begin
            w_width = w_wext;
        end
        if (i_height == '0) begin
            w_height = HB'(1);
        end else if (i_height > mbd_pkg::HEIGHT_LIMIT) begin
            w_height = mbd_pkg::HEIGHT_LIMIT;
        end else begin
            w_height = i_height;
        end
    end

    assign w_dw        = w_width >> 1;
    assign w_dh        = w_height >> 1;
    assign w_dcol      = WW'(r_col >> 1);
    assign w_rhalf     = HB'(r_row >> 1);
    assign w_col_last  = (WW'(r_col) + 1'b1) >= w_width;
    assign w_row_last  = (HB'(r_row) + 1'b1) >= w_height;
    assign w_in_cols   = w_dcol < w_dw;
    assign w_in_rows   = w_rhalf < w_dh;
    assign w_last_dcol = (w_dcol == w_dw - 1'b1);

    assign w_a = mbd_pkg::split_pixel(r_held, i_format);
    assign w_b = mbd_pkg::split_pixel(i_pixel, i_format);

    always_comb begin
        w_cmd.fmt        = i_format;
        w_cmd.sums.red   = {1'b0, w_a.red} + {1'b0, w_b.red};
        w_cmd.sums.green = {1'b0, w_a.green} + {1'b0, w_b.green};
        w_cmd.sums.blue  = {1'b0, w_a.blue} + {1'b0, w_b.blue};
        w_cmd.row_end    = w_last_dcol;
        w_cmd.image_end  = 1'b0;
        w_cmd.kind       = mbd_pkg::CMD_STORE;
        w_has_cmd        = 1'b0;
        if (r_col[0] && w_in_cols) begin
            if (w_height == HB'(1)) begin
                // one-row image: horizontal means, rgb565 only
                w_cmd.kind      = mbd_pkg::CMD_EMIT_PAIR;
                w_cmd.image_end = w_last_dcol;
                w_has_cmd       = (i_format == mbd_pkg::FMT_RGB565);
            end else if (!r_row[0]) begin
                w_cmd.kind = mbd_pkg::CMD_STORE;
                w_has_cmd  = w_in_rows;
            end else begin
                w_cmd.kind      = mbd_pkg::CMD_EMIT_BLOCK;
                w_cmd.image_end = w_last_dcol && (w_rhalf == w_dh - 1'b1);
                w_has_cmd       = w_in_rows;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_held <= '0;
        end else if (i_accept) begin
            if (!r_col[0]) begin
                r_held <= i_pixel;
            end
            if (w_col_last) begin
                r_col <= '0;
                r_row <= w_row_last ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    assign o_cmd_valid = i_accept && w_has_cmd;
    assign o_cmd       = w_cmd;
    assign o_cmd_addr  = r_col[AW:1];

    a_cmd_odd_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_valid |-> r_col[0])
        else $error("command issued on an even column");

    a_image_end_row_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_valid && o_cmd.image_end) |-> o_cmd.row_end)
        else $error("image end without row end");

endmodule

`default_nettype wire

FILE: rtl/mbd_back.sv
// mbd_back: line store of pair sums, averaging and result hand-off
// depends on mbd_pkg
`default_nettype none

module mbd_back #(
    parameter int MAX_WIDTH = mbd_pkg::MAX_WIDTH_DEF,
    parameter int OUT_DEPTH = mbd_pkg::OUT_DEPTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cmd_empty,
    input  wire mbd_pkg::t_cmd                      i_cmd,
    input  wire logic [$clog2(MAX_WIDTH/2)-1:0]     i_cmd_addr,
    output logic                                    o_cmd_pop,
    input  wire logic [$clog2(OUT_DEPTH+1)-1:0]     i_out_count,
    output logic                                    o_out_push,
    output mbd_pkg::t_result                        o_out_data
);

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int QW         = $clog2(OUT_DEPTH + 1);

    mbd_pkg::t_sums r_line [LINE_DEPTH];
    mbd_pkg::t_sums r_rd_data;
    mbd_pkg::t_cmd  r_stage;
    logic           r_stage_valid;

    mbd_pkg::t_rgb  w_avg;
    logic [9:0]     w_red, w_green, w_blue;
    logic           w_is_store;

    // credit check so the result queue can always take the stage
    assign o_cmd_pop  = !i_cmd_empty
                        && ((QW + 1)'(i_out_count) + (QW + 1)'(r_stage_valid)
                            < (QW + 1)'(OUT_DEPTH));
    assign w_is_store = (i_cmd.kind == mbd_pkg::CMD_STORE);

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && w_is_store) begin
            r_line[i_cmd_addr] <= i_cmd.sums;
        end
        r_rd_data <= r_line[i_cmd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_valid <= 1'b0;
        end else begin
            r_stage_valid <= o_cmd_pop && !w_is_store;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_stage <= i_cmd;
        end
    end

    assign w_red   = {1'b0, r_stage.sums.red} + {1'b0, r_rd_data.red};
    assign w_green = {1'b0, r_stage.sums.green} + {1'b0, r_rd_data.green};
    assign w_blue  = {1'b0, r_stage.sums.blue} + {1'b0, r_rd_data.blue};

    always_comb begin
        case (r_stage.kind)
            mbd_pkg::CMD_EMIT_PAIR: begin
                w_avg.red   = r_stage.sums.red[8:1];
                w_avg.green = r_stage.sums.green[8:1];
                w_avg.blue  = r_stage.sums.blue[8:1];
            end
            mbd_pkg::CMD_EMIT_BLOCK: begin
                w_avg.red   = w_red[9:2];
                w_avg.green = w_green[9:2];
                w_avg.blue  = w_blue[9:2];
            end
            default: begin
                w_avg = '0;
            end
        endcase
    end

    assign o_out_push           = r_stage_valid;
    assign o_out_data.pixel     = mbd_pkg::join_pixel(w_avg, r_stage.fmt);
    assign o_out_data.row_end   = r_stage.row_end;
    assign o_out_data.image_end = r_stage.image_end;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stage_valid |-> (i_out_count < QW'(OUT_DEPTH)))
        else $error("result queue has no room for the stage");

    a_stage_is_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stage_valid |-> (r_stage.kind != mbd_pkg::CMD_STORE))
        else $error("store command reached the output stage");

endmodule

`default_nettype wire

FILE: rtl/mipmap_box_downsample_2x2.sv
// mipmap_box_downsample_2x2: top level of the 2x2 box-filter mipmap downsampler
// depends on mbd_pkg, mbd_front, mbd_queue and mbd_back
`default_nettype none

//  channel   direction  handshake             payload
//  source    in         push / full           i_pixel_in[23:0]
//  result    out        pop / empty           o_pixel_out[23:0], o_row_end, o_image_end
//  config    in         psel/penable/pwrite   paddr[3:0], pwdata[31:0] -> prdata[31:0]
//
//  one source item per cycle while full is low; the front classifies each item in the
//  cycle it is taken; the line store serves one command per cycle while the result
//  queue has room; a result is registered in the back stage, then in the result queue
//  reset is synchronous, active low; it clears counters, queues and control registers,
//  not the line store, which is only used at entries written earlier in the image
//  full rises only when the command queue fills, i.e. when pop is held low

module mipmap_box_downsample_2x2 #(
    parameter int MAX_WIDTH = mbd_pkg::MAX_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // source items
    input  wire logic        push,
    output logic             full,
    input  wire logic [23:0] i_pixel_in,
    // result items
    output logic             empty,
    input  wire logic        pop,
    output logic      [23:0] o_pixel_out,
    output logic             o_row_end,
    output logic             o_image_end,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int AW  = $clog2(MAX_WIDTH / 2);
    localparam int HB  = mbd_pkg::CFG_BITS;
    localparam int CMW = AW + $bits(mbd_pkg::t_cmd);

    localparam logic [1:0] REG_FORMAT = 2'd0;
    localparam logic [1:0] REG_WIDTH  = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    // configuration registers
    logic          r_format;
    logic [HB-1:0] r_width;
    logic [HB-1:0] r_height;
    logic          w_cfg_write;
    logic [1:0]    w_reg_idx;

    // front to queue
    logic           w_accept;
    logic           w_cmd_valid;
    mbd_pkg::t_cmd  w_cmd;
    logic [AW-1:0]  w_cmd_addr;

    // queue to back
    logic [CMW-1:0] w_cmd_q_data;
    logic           w_cmd_empty;
    logic           w_cmd_pop;
    mbd_pkg::t_cmd  w_cmd_q;
    logic [AW-1:0]  w_cmd_q_addr;

    // back to result queue
    logic                                    w_out_push;
    mbd_pkg::t_result                        w_out_data;
    mbd_pkg::t_result                        w_out_head;
    logic [$clog2(mbd_pkg::OUT_DEPTH+1)-1:0] w_out_count;

    // apb side: always ready, registers decoded by word address
    assign pready      = 1'b1;
    assign w_reg_idx   = paddr[3:2];
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= mbd_pkg::FMT_RGB565;
            r_width  <= mbd_pkg::WIDTH_RESET;
            r_height <= mbd_pkg::HEIGHT_RESET;
        end else if (w_cfg_write) begin
            case (w_reg_idx)
                REG_FORMAT: r_format <= pwdata[0];
                REG_WIDTH:  r_width  <= pwdata[HB-1:0];
                REG_HEIGHT: r_height <= pwdata[HB-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_FORMAT: prdata = {31'd0, r_format};
            REG_WIDTH:  prdata = {{(32 - HB){1'b0}}, r_width};
            REG_HEIGHT: prdata = {{(32 - HB){1'b0}}, r_height};
            default:    prdata = '0;
        endcase
    end

    // front: every accepted item moves the raster position
    assign w_accept = push && !full;

    mbd_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_pixel     (i_pixel_in),
        .i_format    (r_format),
        .i_width     (r_width),
        .i_height    (r_height),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .o_cmd_addr  (w_cmd_addr)
    );

    // command queue decouples the front from line store work
    mbd_queue #(
        .WIDTH (CMW),
        .DEPTH (mbd_pkg::CMD_DEPTH)
    ) u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_valid),
        .i_data  ({w_cmd_addr, w_cmd}),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmd_q_data),
        .o_full  (full),
        .o_empty (w_cmd_empty),
        .o_count ()
    );

    assign w_cmd_q      = mbd_pkg::t_cmd'(w_cmd_q_data[CMW-AW-1:0]);
    assign w_cmd_q_addr = w_cmd_q_data[CMW-1:CMW-AW];

    mbd_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .OUT_DEPTH (mbd_pkg::OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (w_cmd_empty),
        .i_cmd       (w_cmd_q),
        .i_cmd_addr  (w_cmd_q_addr),
        .o_cmd_pop   (w_cmd_pop),
        .i_out_count (w_out_count),
        .o_out_push  (w_out_push),
        .o_out_data  (w_out_data)
    );

    // result queue doubles as the output register
    mbd_queue #(
        .WIDTH ($bits(mbd_pkg::t_result)),
        .DEPTH (mbd_pkg::OUT_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_out_push),
        .i_data  (w_out_data),
        .i_pop   (pop),
        .o_data  (w_out_head),
        .o_full  (),
        .o_empty (empty),
        .o_count (w_out_count)
    );

    assign o_pixel_out = w_out_head.pixel;
    assign o_row_end   = w_out_head.row_end;
    assign o_image_end = w_out_head.image_end;

    a_rgb565_high_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_push && (w_out_data.pixel[23:16] != 8'h00)) |-> $past(r_format))
        else $error("rgb565 result with upper byte set");

endmodule

`default_nettype wire
